/* src/metric_prefix_scaler_assert.svh */
// Assertion macros shared by the checker file of the metric prefix scaler.
// Depends on nothing; include by bare file name.
`ifndef METRIC_PREFIX_SCALER_ASSERT_SVH
`define METRIC_PREFIX_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define MPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mps_pkg.sv */
// Shared types and constants of the metric prefix scaler.
// Used by the divider, the sequencer and the top level; depends on nothing.
package mps_pkg;

  localparam int unsigned PREFIX_COUNT_DEF = 8;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned UNIT_W  = 8;
  localparam int unsigned PROD_W  = VAL_W + BASE_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned OUT_W       = VAL_W + FRAC_W + 1 + IDX_W + UNIT_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OMIT_ZERO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SYMBOL   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DIV_W-1:0]  DIVISOR_RST = 32'd1;
  localparam logic [BASE_W-1:0] BASE_RST    = 16'd1000;

  // Fixed multiplicands for the fraction digits
  localparam logic [BASE_W-1:0] MUL_HUNDRED = 16'd100;
  localparam logic [BASE_W-1:0] MUL_TEN     = 16'd10;

  typedef struct packed {
    logic [DIV_W-1:0]  fixed_divisor;
    logic [BASE_W-1:0] prefix_base;
    logic              omit_zero_fraction;
    logic [UNIT_W-1:0] unit_symbol;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quo;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0]  whole_part;
    logic [FRAC_W-1:0] fraction_part;
    logic              fraction_shown;
    logic [IDX_W-1:0]  prefix_index;
    logic [UNIT_W-1:0] unit_out;
    logic              invalid;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_SCALE,
    S_W_SCALE,
    S_MUL_POW,
    S_TEST,
    S_ADJUST,
    S_L_WHOLE,
    S_W_WHOLE,
    S_L_QUOT,
    S_W_QUOT,
    S_MUL_100,
    S_L_BASE,
    S_W_BASE,
    S_MUL_10,
    S_L_FRAC,
    S_W_FRAC,
    S_DONE
  } seq_state_t;

endpackage

/* src/mps_div.sv */
// Bit-serial restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on mps_pkg for widths and the request/response structs.
module mps_div (
  input  logic              clk,
  input  logic              rst,
  input  mps_pkg::div_req_t req,
  output mps_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(mps_pkg::VAL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mps_pkg::VAL_W - 1);

  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic [mps_pkg::VAL_W:0]   rem;
  logic [mps_pkg::VAL_W-1:0] quo;
  logic [mps_pkg::VAL_W-1:0] den;

  logic [mps_pkg::VAL_W:0]   shifted;
  logic [mps_pkg::VAL_W:0]   diff;
  logic                     fits;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    shifted = {rem[mps_pkg::VAL_W-1:0], quo[mps_pkg::VAL_W-1]};
    diff    = shifted - {1'b0, den};
    fits    = shifted >= {1'b0, den};
  end

  // Control: count the quotient bits while busy and flag done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? diff : shifted;
      quo <= {quo[mps_pkg::VAL_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[mps_pkg::VAL_W-1:0];

endmodule

/* src/mps_seq.sv */
// Sequencer and datapath of the metric prefix scaler: prefix search with a
// shared 64x16 multiplier, and fraction work on the shared divider.
// Depends on mps_pkg; drives mps_div through its request/response structs.
module mps_seq #(
  parameter int unsigned PREFIX_COUNT = mps_pkg::PREFIX_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mps_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [mps_pkg::VAL_W-1:0] in_value,
  output logic                      idle,
  input  logic                      out_free,
  output logic                      res_valid,
  output mps_pkg::result_t          res,
  output mps_pkg::div_req_t         div_req,
  input  mps_pkg::div_rsp_t         div_rsp
);

  localparam int unsigned VW = mps_pkg::VAL_W;
  localparam int unsigned PW = mps_pkg::PROD_W;
  localparam int unsigned IW = mps_pkg::IDX_W;

  mps_pkg::seq_state_t state, state_next;

  logic [VW-1:0]           val;
  logic [VW-1:0]           scaled;
  logic [mps_pkg::DIV_W-1:0] rem0;
  logic [VW-1:0]           dv;
  logic [VW-1:0]           dv_prev;
  logic [VW-1:0]           dv_pp;
  logic [VW-1:0]           tmp;
  logic [PW-1:0]           prod;
  logic [IW-1:0]           steps;
  logic [VW-1:0]           whole;
  logic [mps_pkg::FRAC_W-1:0] frac;
  logic                    shown;
  logic                    scaled_path;
  logic                    inv;

  logic [VW-1:0]           base64;
  logic [VW-1:0]           dec64;
  logic                    cfg_bad;
  logic                    ovf;
  logic                    step_ok;
  logic                    dv_is_base;
  logic [VW-1:0]           frac_den;
  logic                    grow;
  logic [VW-1:0]           mul_a;
  logic [mps_pkg::BASE_W-1:0] mul_b;
  logic [PW-1:0]           mul_p;

  // Common decodes
  always_comb begin
    base64     = VW'(cfg.prefix_base);
    dec64      = VW'(cfg.fixed_divisor);
    cfg_bad    = (cfg.fixed_divisor == '0) || (cfg.prefix_base == '0);
    ovf        = |prod[PW-1:VW];
    step_ok    = steps < IW'(PREFIX_COUNT);
    dv_is_base = dv == base64;
    frac_den   = dv_is_base ? dv : dv_prev;
    grow       = !ovf && (scaled >= dv) && step_ok;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mps_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = cfg_bad ? mps_pkg::S_DONE : mps_pkg::S_L_SCALE;
        end
      end
      mps_pkg::S_L_SCALE: state_next = mps_pkg::S_W_SCALE;
      mps_pkg::S_W_SCALE: begin
        if (div_rsp.done) begin
          state_next = mps_pkg::S_MUL_POW;
        end
      end
      mps_pkg::S_MUL_POW: state_next = mps_pkg::S_TEST;
      mps_pkg::S_TEST: state_next = grow ? mps_pkg::S_MUL_POW : mps_pkg::S_ADJUST;
      mps_pkg::S_ADJUST: begin
        if (!dv_is_base) begin
          state_next = mps_pkg::S_L_WHOLE;
        end else if (cfg.omit_zero_fraction && (rem0 == '0)) begin
          state_next = mps_pkg::S_DONE;
        end else if (dec64 > base64) begin
          state_next = mps_pkg::S_L_BASE;
        end else begin
          state_next = mps_pkg::S_MUL_10;
        end
      end
      mps_pkg::S_L_WHOLE: state_next = mps_pkg::S_W_WHOLE;
      mps_pkg::S_W_WHOLE: begin
        if (div_rsp.done) begin
          if (cfg.omit_zero_fraction && (div_rsp.rem == '0)) begin
            state_next = mps_pkg::S_DONE;
          end else if (dv_is_base) begin
            state_next = mps_pkg::S_MUL_100;
          end else begin
            state_next = mps_pkg::S_L_QUOT;
          end
        end
      end
      mps_pkg::S_L_QUOT: state_next = mps_pkg::S_W_QUOT;
      mps_pkg::S_W_QUOT: begin
        if (div_rsp.done) begin
          state_next = mps_pkg::S_MUL_100;
        end
      end
      mps_pkg::S_MUL_100: state_next = mps_pkg::S_L_FRAC;
      mps_pkg::S_L_BASE: state_next = mps_pkg::S_W_BASE;
      mps_pkg::S_W_BASE: begin
        if (div_rsp.done) begin
          state_next = mps_pkg::S_MUL_10;
        end
      end
      mps_pkg::S_MUL_10: state_next = mps_pkg::S_L_FRAC;
      mps_pkg::S_L_FRAC: state_next = mps_pkg::S_W_FRAC;
      mps_pkg::S_W_FRAC: begin
        if (div_rsp.done) begin
          state_next = mps_pkg::S_DONE;
        end
      end
      mps_pkg::S_DONE: begin
        if (out_free) begin
          state_next = mps_pkg::S_IDLE;
        end
      end
      default: state_next = mps_pkg::S_IDLE;
    endcase
  end

  // Outputs: divider launches, multiplier operands, handshake flags
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = val;
    div_req.den   = dec64;
    mul_a         = tmp;
    mul_b         = mps_pkg::MUL_TEN;
    idle          = 1'b0;
    res_valid     = 1'b0;
    case (state)
      mps_pkg::S_IDLE: idle = 1'b1;
      mps_pkg::S_L_SCALE: begin
        div_req.start = 1'b1;
        div_req.num   = val;
        div_req.den   = dec64;
      end
      mps_pkg::S_MUL_POW: begin
        mul_a = dv;
        mul_b = cfg.prefix_base;
      end
      mps_pkg::S_L_WHOLE: begin
        div_req.start = 1'b1;
        div_req.num   = scaled;
        div_req.den   = dv;
      end
      mps_pkg::S_L_QUOT: begin
        div_req.start = 1'b1;
        div_req.num   = tmp;
        div_req.den   = base64;
      end
      mps_pkg::S_MUL_100: begin
        mul_a = tmp;
        mul_b = mps_pkg::MUL_HUNDRED;
      end
      mps_pkg::S_L_BASE: begin
        div_req.start = 1'b1;
        div_req.num   = dec64;
        div_req.den   = base64;
      end
      mps_pkg::S_MUL_10: begin
        mul_a = tmp;
        mul_b = mps_pkg::MUL_TEN;
      end
      mps_pkg::S_L_FRAC: begin
        div_req.start = 1'b1;
        div_req.num   = scaled_path ? prod[VW-1:0] : VW'(rem0);
        div_req.den   = scaled_path ? frac_den : prod[VW-1:0];
      end
      mps_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // Shared multiplier
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mps_pkg::S_IDLE: begin
        if (in_valid) begin
          val         <= in_value;
          inv         <= cfg_bad;
          whole       <= '0;
          frac        <= '0;
          shown       <= 1'b0;
          scaled_path <= 1'b0;
          steps       <= '0;
        end
      end
      mps_pkg::S_W_SCALE: begin
        if (div_rsp.done) begin
          scaled  <= div_rsp.quo;
          rem0    <= div_rsp.rem[mps_pkg::DIV_W-1:0];
          dv      <= base64;
          dv_prev <= VW'(1);
          steps   <= '0;
        end
      end
      mps_pkg::S_MUL_POW, mps_pkg::S_MUL_100, mps_pkg::S_MUL_10: prod <= mul_p;
      mps_pkg::S_TEST: begin
        // Advance one power of the base
        if (grow) begin
          dv_pp   <= dv_prev;
          dv_prev <= dv;
          dv      <= prod[VW-1:0];
          steps   <= steps + IW'(1);
        end
      end
      mps_pkg::S_ADJUST: begin
        if (!dv_is_base) begin
          scaled_path <= 1'b1;
          // Promote on the undivided value, else drop back one power
          if ((val >= dv) && step_ok) begin
            steps <= steps + IW'(1);
          end else begin
            dv      <= dv_prev;
            dv_prev <= dv_pp;
          end
        end else begin
          whole <= scaled;
          tmp   <= VW'(1);
        end
      end
      mps_pkg::S_W_WHOLE: begin
        if (div_rsp.done) begin
          whole <= div_rsp.quo;
          tmp   <= div_rsp.rem;
        end
      end
      mps_pkg::S_W_QUOT, mps_pkg::S_W_BASE: begin
        if (div_rsp.done) begin
          tmp <= div_rsp.quo;
        end
      end
      mps_pkg::S_W_FRAC: begin
        if (div_rsp.done) begin
          frac  <= div_rsp.quo[mps_pkg::FRAC_W-1:0];
          shown <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    res.whole_part     = whole;
    res.fraction_part  = frac;
    res.fraction_shown = shown;
    res.prefix_index   = scaled_path ? steps : '0;
    res.unit_out       = scaled_path ? cfg.unit_symbol : '0;
    res.invalid        = inv;
  end

endmodule

/* src/metric_prefix_scaler.sv */
// Metric prefix scaler, one item at a time: the bit-serial divider runs one to four
// times an item, plus a prefix test on the shared multiplier per power of the base.
// An invalid configuration skips the divider and goes straight to the result. No
// new item is taken until the result has been handed to the output register.
// rst is synchronous, active high: it empties the output register, idles the
// sequencer and loads the configuration registers with their defaults.
module metric_prefix_scaler #(
  parameter int unsigned PREFIX_COUNT = mps_pkg::PREFIX_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // raw_value[63:0]
  input  logic [mps_pkg::VAL_W-1:0]       s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // whole_part[63:0], fraction_part[95:64], fraction_shown[96],
  // prefix_index[100:97], unit_out[108:101], invalid[109], zero pad[111:110]
  output logic [mps_pkg::OUT_TDATA_W-1:0] m_tdata
);

  mps_pkg::cfg_t      cfg;
  mps_pkg::result_t   res;
  mps_pkg::div_req_t  div_req;
  mps_pkg::div_rsp_t  div_rsp;
  logic               idle;
  logic               res_valid;
  logic               out_free;
  logic               in_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_divisor      <= mps_pkg::DIVISOR_RST;
      cfg.prefix_base        <= mps_pkg::BASE_RST;
      cfg.omit_zero_fraction <= 1'b0;
      cfg.unit_symbol        <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        mps_pkg::REG_FIXED_DIVISOR: cfg.fixed_divisor <= cfg_wdata[mps_pkg::DIV_W-1:0];
        mps_pkg::REG_PREFIX_BASE:   cfg.prefix_base <= cfg_wdata[mps_pkg::BASE_W-1:0];
        mps_pkg::REG_OMIT_ZERO:     cfg.omit_zero_fraction <= cfg_wdata[0];
        mps_pkg::REG_UNIT_SYMBOL:   cfg.unit_symbol <= cfg_wdata[mps_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: take an item whenever the sequencer is idle
  assign s_tready  = idle;
  assign in_accept = s_tvalid && idle;

  // Output register frees the sequencer as soon as it is taken or empty
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= {(mps_pkg::OUT_TDATA_W - mps_pkg::OUT_W)'(0), res.invalid, res.unit_out,
                  res.prefix_index, res.fraction_shown, res.fraction_part, res.whole_part};
    end
  end

  mps_seq #(
    .PREFIX_COUNT(PREFIX_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_accept),
    .in_value (s_tdata),
    .idle     (idle),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  mps_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule

/* src/mps_checker.sv */
// Port-level checks of the metric prefix scaler, bound to the top level.
// Depends on metric_prefix_scaler_assert.svh and mps_pkg for widths.
`include "metric_prefix_scaler_assert.svh"

module mps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mps_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result item holds
  `MPS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // One item at a time: no second item straight after an accept
  `MPS_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")

  // An invalid result carries zeros elsewhere
  `MPS_ASSERT_NOW(a_inv_zero, clk, rst, m_tvalid && m_tdata[109], m_tdata[108:0] == '0, "invalid result with nonzero fields")

  // No unit without a prefix, and the prefix stays in the table
  `MPS_ASSERT_NOW(a_unit_idx, clk, rst, m_tvalid, (m_tdata[100:97] <= 4'd8) && ((m_tdata[100:97] != 4'd0) || (m_tdata[108:101] == 8'd0)), "bad prefix index or unit")

endmodule

bind metric_prefix_scaler mps_checker u_mps_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* verif/metric_prefix_scaler_tb.sv */
// Self-checking testbench of the metric prefix scaler: streams 64-bit values in
// under several register settings and compares every result with its own prediction.
// Depends on mps_pkg and metric_prefix_scaler only.
`timescale 1ns / 1ps

module metric_prefix_scaler_tb;
  import mps_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_AFTER   = 420;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  // Expected results of accepted values, with a private copy of the registers
  class scaler_scoreboard;
    logic [DIV_W-1:0]  divisor;
    logic [BASE_W-1:0] base;
    logic              omit_zero;
    logic [UNIT_W-1:0] unit;
    result_t           awaited[$];
    int unsigned       errors;

    function new();
      divisor   = DIVISOR_RST;
      base      = BASE_RST;
      omit_zero = 1'b0;
      unit      = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FIXED_DIVISOR: divisor = data[DIV_W-1:0];
        REG_PREFIX_BASE:   base = data[BASE_W-1:0];
        REG_OMIT_ZERO:     omit_zero = data[0];
        REG_UNIT_SYMBOL:   unit = data[UNIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Scale one value: divide, search the prefix power, then split off the fraction
    function result_t scale_value(logic [VAL_W-1:0] raw);
      logic [VAL_W-1:0] dec, mult, scaled, pow, rem, divider, frac;
      int unsigned      steps;
      logic             at_limit;
      result_t          r;
      r        = '0;
      dec      = VAL_W'(divisor);
      mult     = VAL_W'(base);
      steps    = 0;
      at_limit = 1'b0;
      frac     = '0;
      if (dec == 0 || mult == 0) begin
        r.invalid = 1'b1;
        return r;
      end
      scaled = raw / dec;
      pow    = mult;
      // Stop one step short of 64-bit overflow
      while (!at_limit && scaled >= pow && steps < PREFIX_COUNT_DEF) begin
        pow      = pow * mult;
        steps++;
        at_limit = (ALL_ONES / pow) < mult;
      end
      if (pow != mult) begin
        // Promotion is tested on the undivided value
        if (raw / pow > 0 && steps < PREFIX_COUNT_DEF)
          steps++;
        else
          pow = pow / mult;
        rem          = scaled % pow;
        r.whole_part = scaled / pow;
        if (omit_zero && rem == 0) begin
          r.fraction_shown = 1'b0;
        end else begin
          if (pow == mult)
            frac = rem * 64'd100 / pow;
          else
            frac = (rem / mult * 64'd100) / (pow / mult);
          r.fraction_shown = 1'b1;
        end
        r.prefix_index = steps[IDX_W-1:0];
        r.unit_out     = unit;
      end else begin
        r.whole_part = scaled;
        if (omit_zero && (raw % dec) == 0) begin
          r.fraction_shown = 1'b0;
        end else begin
          divider          = ((dec > mult) ? dec / mult : 64'd1) * 64'd10;
          frac             = (raw % dec) / divider;
          r.fraction_shown = 1'b1;
        end
      end
      r.fraction_part = frac[FRAC_W-1:0];
      return r;
    endfunction

    function void note_value(logic [VAL_W-1:0] raw);
      awaited.push_back(scale_value(raw));
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Fields from the lowest bit: whole, fraction, shown, prefix, unit, invalid
    function void check_result(logic [OUT_TDATA_W-1:0] t);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, t);
        return;
      end
      want = awaited.pop_front();
      compare_field("whole_part", want.whole_part, t[63:0]);
      compare_field("fraction_part", VAL_W'(want.fraction_part), VAL_W'(t[95:64]));
      compare_field("fraction_shown", VAL_W'(want.fraction_shown), VAL_W'(t[96]));
      compare_field("prefix_index", VAL_W'(want.prefix_index), VAL_W'(t[100:97]));
      compare_field("unit_out", VAL_W'(want.unit_out), VAL_W'(t[108:101]));
      compare_field("invalid", VAL_W'(want.invalid), VAL_W'(t[109]));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [VAL_W-1:0]       s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  scaler_scoreboard  board;
  logic [VAL_W-1:0]  directed[$];
  int unsigned       inputs_taken = 0;
  int unsigned       cycles = 0;
  bit                hold_done = 1'b0;

  metric_prefix_scaler u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata);
  end

  // Receiver: short stalls, free-flowing stretches and one long hold-off
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && inputs_taken >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Values around powers of the base, multiples, extremes and plain noise
  function automatic logic [VAL_W-1:0] pick_value(logic [VAL_W-1:0] mult,
                                                  logic [VAL_W-1:0] dec);
    logic [VAL_W-1:0] v, p;
    int unsigned      k;
    p = 64'd1;
    k = $urandom_range(0, PREFIX_COUNT_DEF);
    repeat (k) p = p * mult;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: begin
        v = {$urandom, $urandom};
        v = v >> $urandom_range(0, 63);
      end
      2: v = p * dec + 64'($urandom_range(0, 2)) - 64'd1;
      3: v = 64'($urandom_range(0, 4000));
      4: v = ($urandom_range(0, 1) == 1) ? ALL_ONES : 64'h8000_0000_0000_0000;
      default: v = p * dec * 64'($urandom_range(1, 999));
    endcase
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  task automatic configure(logic [31:0] div, logic [31:0] base, logic [31:0] omit,
                           logic [31:0] unit);
    write_reg(REG_FIXED_DIVISOR, div);
    write_reg(REG_PREFIX_BASE, base);
    write_reg(REG_OMIT_ZERO, omit);
    write_reg(REG_UNIT_SYMBOL, unit);
    cfg_wen <= 1'b0;
  endtask

  // Offer one item and hold it until taken
  task automatic push_value(logic [VAL_W-1:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_value(v);
    inputs_taken++;
  endtask

  // Send the queued directed values, then random ones, in bursts with gaps
  task automatic send_items(int unsigned n_random);
    int unsigned      total, burst_left, gap;
    logic [VAL_W-1:0] v;
    total      = directed.size() + n_random;
    burst_left = $urandom_range(1, 16);
    for (int unsigned i = 0; i < total; i++) begin
      if (directed.size() != 0)
        v = directed.pop_front();
      else
        v = pick_value(VAL_W'(board.base), VAL_W'(board.divisor));
      push_value(v);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        case ($urandom_range(0, 3))
          0:       gap = 0;
          1:       gap = $urandom_range(1, 400);
          default: gap = $urandom_range(1, 8);
        endcase
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
    // Registers change only once every result is back
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_index <= REG_FIXED_DIVISOR;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: boundaries of the decimal prefixes and the field extremes
    directed.push_back(64'd0);
    directed.push_back(64'd1);
    directed.push_back(64'd999);
    directed.push_back(64'd1000);
    directed.push_back(64'd1001);
    directed.push_back(64'd999_999);
    directed.push_back(64'd1_000_000);
    directed.push_back(64'd1_500_000);
    directed.push_back(64'd1_000_000_000_000_000_000);
    directed.push_back(64'd999_999_999_999_999_999);
    directed.push_back(64'h8000_0000_0000_0000);
    directed.push_back(ALL_ONES);
    directed.push_back(64'd12_345_678_901);
    send_items(60);

    configure(32'd1, 32'd1024, 32'd1, "B");
    send_items(60);

    // Zero divisor: invalid
    configure(32'd0, 32'd1000, 32'd0, "V");
    directed.push_back(64'd12_345);
    send_items(15);

    // Divisor above one: promotion on the undivided value
    configure(32'd1000, 32'd1000, 32'd0, "W");
    directed.push_back(64'd1_000_000);
    send_items(50);

    configure(32'hFFFF_FFFF, 32'd65535, 32'd1, 32'd255);
    send_items(40);

    // Zero base: invalid
    configure(32'd1, 32'd0, 32'd0, "A");
    directed.push_back(64'd5_000);
    send_items(15);

    // Base of one never scales
    configure(32'd1, 32'd1, 32'd1, "Q");
    directed.push_back(64'd1_000_000);
    send_items(30);

    // Base of two runs out of prefixes
    configure(32'd1, 32'd2, 32'd0, 32'd0);
    directed.push_back(64'd1 << 20);
    directed.push_back(64'h8000_0000_0000_0000);
    send_items(60);

    configure($urandom_range(1, 1000), $urandom_range(2, 65535), $urandom_range(0, 1),
              $urandom_range(1, 255));
    send_items(200);

    // Divisor above the base while unscaled
    configure(32'd5000, 32'd1000, 32'd0, "s");
    directed.push_back(64'd4999);
    directed.push_back(64'd4_995_000);
    send_items(50);

    configure(32'd3, 32'd10, 32'd1, "x");
    send_items(60);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/mps_pkg.sv
src/mps_div.sv
src/mps_seq.sv
src/metric_prefix_scaler.sv
src/mps_checker.sv
verif/metric_prefix_scaler_tb.sv
